>>> hdl/mpf_pkg.sv
`default_nettype none

package mpf_pkg;

    localparam int FRAC          = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int HYP_STAGES    = 18;
    localparam int CW            = 20;
    localparam int ZW            = 18;
    localparam int PW            = 32;
    localparam int DW            = 18;
    localparam int NW            = 30;
    localparam int QB            = 19;
    localparam int RW            = 17;
    localparam int QW            = 22;
    localparam int VW            = 17;
    localparam int BW            = 5;

    typedef enum logic [1:0] {
        MODE_STEREO   = 2'd0,
        MODE_ORTHO    = 2'd1,
        MODE_MERCATOR = 2'd2
    } mode_t;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] ang_t;
    typedef logic signed [QW-1:0] qval_t;

    localparam ang_t  HALF_PI     = 18'sd25735;
    localparam ang_t  PI_Q        = 18'sd51471;
    localparam cval_t CORDIC_GAIN = 20'sd9949;
    localparam cval_t ONE         = 20'sd16384;
    localparam logic signed [15:0] LN2_Q = 16'sd11356;
    localparam qval_t BIG_Q       = 22'sd1048576;
    localparam qval_t ROUND_HALF  = 22'sd4;
    localparam qval_t Q11_MAX     = 22'sd32767;
    localparam qval_t Q11_MIN     = -22'sd32768;

    typedef struct packed {
        cval_t x;
        cval_t y;
        ang_t  z;
        logic  neg;
    } rot_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        ang_t  z;
    } hyp_t;

    typedef struct packed {
        logic [BW-1:0] b;
        hyp_t          h;
    } llane_t;

    typedef struct packed {
        logic [NW-1:0] mag;
        logic          neg;
        logic          zero;
    } num_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] low;
        logic [QB-1:0] quo;
        logic          neg;
        logic          ovf;
        logic          zero;
    } dlane_t;

    typedef struct packed {
        mode_t               mode;
        logic signed [15:0]  lon;
    } head_t;

    typedef struct packed {
        mode_t               mode;
        logic signed [15:0]  lon;
        qval_t               m1x;
        qval_t               m1y;
        logic                pole_neg;
        logic                pole_pos;
    } tail_t;

    typedef struct packed {
        logic signed [15:0] val;
        logic               clip;
    } sat_t;

    function automatic ang_t atan_q(input int k);
        ang_t r;
        case (k)
            0:       r = 18'sd12867;
            1:       r = 18'sd7596;
            2:       r = 18'sd4013;
            3:       r = 18'sd2037;
            4:       r = 18'sd1022;
            5:       r = 18'sd511;
            6:       r = 18'sd255;
            7:       r = 18'sd127;
            8:       r = 18'sd63;
            9:       r = 18'sd31;
            10:      r = 18'sd15;
            11:      r = 18'sd7;
            12:      r = 18'sd3;
            13:      r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    function automatic ang_t atanh_q(input int i);
        ang_t r;
        case (i)
            1:       r = 18'sd8999;
            2:       r = 18'sd4184;
            3:       r = 18'sd2058;
            4:       r = 18'sd1025;
            5:       r = 18'sd512;
            6:       r = 18'sd256;
            7:       r = 18'sd128;
            8:       r = 18'sd64;
            9:       r = 18'sd32;
            10:      r = 18'sd16;
            11:      r = 18'sd8;
            12:      r = 18'sd4;
            13:      r = 18'sd2;
            14:      r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // Shift of each hyperbolic stage; shifts 4 and 13 appear twice for convergence.
    function automatic int hyp_shift(input int k);
        int r;
        if (k < 4) r = k + 1;
        else if (k < 14) r = k;
        else r = k - 1;
        return r;
    endfunction

    // Angles beyond a quarter turn are moved by pi; the results are negated later.
    function automatic rot_t reduce(input ang_t a);
        rot_t r;
        r.x   = CORDIC_GAIN;
        r.y   = '0;
        r.z   = a;
        r.neg = 1'b0;
        if (a > HALF_PI) begin
            r.z   = a - PI_Q;
            r.neg = 1'b1;
        end else if (a < -HALF_PI) begin
            r.z   = a + PI_Q;
            r.neg = 1'b1;
        end
        return r;
    endfunction

    function automatic rot_t rot_step(input rot_t s, input int k);
        rot_t  r;
        cval_t dx;
        cval_t dy;
        dx = s.x;
        dy = s.y;
        dx = dy >>> k;
        dy = s.x >>> k;
        r  = s;
        if (!s.z[ZW-1]) begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - atan_q(k);
        end else begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + atan_q(k);
        end
        return r;
    endfunction

    function automatic hyp_t hyp_step(input hyp_t s, input int i);
        hyp_t  r;
        cval_t dx;
        cval_t dy;
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (!s.y[CW-1]) begin
            r.x = s.x - dx;
            r.y = s.y - dy;
            r.z = s.z + atanh_q(i);
        end else begin
            r.x = s.x + dx;
            r.y = s.y + dy;
            r.z = s.z - atanh_q(i);
        end
        return r;
    endfunction

    function automatic logic [BW-1:0] lead_one(input logic [VW-1:0] v);
        logic [BW-1:0] b;
        b = '0;
        for (int i = 0; i < VW; i++) begin
            if (v[i]) b = BW'(i);
        end
        return b;
    endfunction

    // Mantissa in [1, 2) as x = m + 1, y = m - 1 for the logarithm.
    function automatic llane_t lane_init(input logic [VW-1:0] v, input logic [BW-1:0] b);
        llane_t        r;
        logic [VW-1:0] sh;
        logic [14:0]   m;
        sh = (b >= 5'd14) ? (v >> (b - 5'd14)) : (v << (5'd14 - b));
        m  = sh[14:0];
        r.b   = b;
        r.h.x = CW'($signed({1'b0, m})) + ONE;
        r.h.y = CW'($signed({1'b0, m})) - ONE;
        r.h.z = '0;
        return r;
    endfunction

    function automatic qval_t ln_finish(input llane_t l);
        logic signed [5:0] e;
        e = $signed({1'b0, l.b}) - 6'sd14;
        return QW'(e) * QW'(LN2_Q) + (QW'(l.h.z) <<< 1);
    endfunction

    function automatic dlane_t div_init(input num_t n, input logic [RW-1:0] dv);
        dlane_t r;
        r.rem  = RW'(n.mag[NW-1:QB]);
        r.low  = n.mag[QB-1:0];
        r.quo  = '0;
        r.neg  = n.neg;
        r.zero = n.zero;
        r.ovf  = !n.zero && (RW'(n.mag[NW-1:QB]) >= dv);
        return r;
    endfunction

    function automatic dlane_t div_step(input dlane_t l, input logic [RW-1:0] dv);
        dlane_t        r;
        logic [RW-1:0] r2;
        r2    = {l.rem[RW-2:0], l.low[QB-1]};
        r     = l;
        r.low = l.low << 1;
        if (r2 >= dv) begin
            r.rem = r2 - dv;
            r.quo = {l.quo[QB-2:0], 1'b1};
        end else begin
            r.rem = r2;
            r.quo = {l.quo[QB-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic qval_t q_value(input dlane_t l);
        qval_t r;
        if (l.zero) r = '0;
        else if (l.ovf) r = l.neg ? -BIG_Q : BIG_Q;
        else r = l.neg ? -$signed(QW'(l.quo)) : $signed(QW'(l.quo));
        return r;
    endfunction

    // Round a Q14 value to Q11 half up and clip to 16 bits.
    function automatic sat_t sat_q11(input qval_t v);
        sat_t  s;
        qval_t r;
        r = (v + ROUND_HALF) >>> 3;
        s.clip = 1'b0;
        if (r > Q11_MAX) begin
            r = Q11_MAX;
            s.clip = 1'b1;
        end else if (r < Q11_MIN) begin
            r = Q11_MIN;
            s.clip = 1'b1;
        end
        s.val = r[15:0];
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mpf_in_if.sv
`default_nettype none

interface mpf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] longitude;
    logic signed [15:0] latitude;

    modport source (output valid, output longitude, output latitude, input ready);
    modport sink (input valid, input longitude, input latitude, output ready);
endinterface

`default_nettype wire

>>> hdl/mpf_out_if.sv
`default_nettype none

interface mpf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] proj_x;
    logic signed [15:0] proj_y;
    logic               saturated;

    modport source (output valid, output proj_x, output proj_y, output saturated, input ready);
    modport sink (input valid, input proj_x, input proj_y, input saturated, output ready);
endinterface

`default_nettype wire

>>> hdl/map_projection_forward.sv
// Channel   Dir  Handshake       Payload
// coord     in   valid/ready     longitude, latitude (signed Q2.13 radians)
// result    out  valid/ready     proj_x, proj_y (signed Q4.11), saturated
// cfg       in   cfg_wr_en       cfg_wr_data: projection mode
//
// One point enters per cycle while the output is not stalled. The pipeline runs the
// 16-stage rotation CORDIC, then a 22-stage section that holds the 19-step restoring
// divider and, beside it, the 18-stage hyperbolic log CORDIC.
// Reset clears the valid bits and sets the mode to stereographic.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module map_projection_forward (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    mpf_in_if.sink            coord,
    mpf_out_if.source         result
);
    import mpf_pkg::*;

    localparam int BR = 3 + QB;
    localparam int NV = 1 + CORDIC_STAGES + 2 + BR + 1;

    logic          adv;
    logic [NV-1:0] vld_reg;
    logic          out_vld_reg;
    mode_t         mode_reg;

    ang_t   lat_ang;
    ang_t   lon_ang;
    rot_t   rl_reg [0:CORDIC_STAGES];
    rot_t   ra_reg [0:CORDIC_STAGES];
    head_t  hd_reg [0:CORDIC_STAGES+2];

    cval_t  cl_reg, sl_reg, ca_reg, sa_reg;
    logic signed [PW-1:0] prod_d_reg, prod_x_reg;
    cval_t  sl_m_reg, cl_m_reg;

    // Divider side
    logic signed [DW-1:0] d0_reg;
    num_t   nx0_reg, ny0_reg, nx1_reg, ny1_reg;
    logic [RW-1:0] dv1_reg;
    logic [RW-1:0] dv_reg [0:QB];
    dlane_t dlx_reg [0:QB];
    dlane_t dly_reg [0:QB];

    // Logarithm side
    qval_t  p_next;
    logic [VW-1:0] lvp0_reg, lvc0_reg, lvp1_reg, lvc1_reg;
    logic [BW-1:0] lbp1_reg, lbc1_reg;
    llane_t lnp_reg [0:HYP_STAGES];
    llane_t lnc_reg [0:HYP_STAGES];
    qval_t  lnp_reg_f, lnc_reg_f;

    tail_t  tail_reg [0:BR-1];
    tail_t  tl;

    qval_t  xq_next, yq_next, xq_reg, yq_reg;
    sat_t   sx, sy;
    logic signed [15:0] px_reg, py_reg;
    logic   sat_reg;

    assign adv         = !out_vld_reg || result.ready;
    assign coord.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STEREO;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NV-2:0], coord.valid};
            out_vld_reg <= vld_reg[NV-1];
        end
    end

    // Stereographic works on half the longitude, so its angle keeps the Q13 bits as Q14.
    assign lat_ang = {coord.latitude[15], coord.latitude, 1'b0};
    assign lon_ang = (mode_reg == MODE_STEREO) ?
                     {{2{coord.longitude[15]}}, coord.longitude} :
                     {coord.longitude[15], coord.longitude, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rl_reg[0] <= reduce(lat_ang);
            ra_reg[0] <= reduce(lon_ang);
            hd_reg[0] <= '{mode: mode_reg, lon: coord.longitude};
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rl_reg[k+1] <= rot_step(rl_reg[k], k);
                ra_reg[k+1] <= rot_step(ra_reg[k], k);
                hd_reg[k+1] <= hd_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl_reg <= rl_reg[CORDIC_STAGES].neg ? -rl_reg[CORDIC_STAGES].x : rl_reg[CORDIC_STAGES].x;
            sl_reg <= rl_reg[CORDIC_STAGES].neg ? -rl_reg[CORDIC_STAGES].y : rl_reg[CORDIC_STAGES].y;
            ca_reg <= ra_reg[CORDIC_STAGES].neg ? -ra_reg[CORDIC_STAGES].x : ra_reg[CORDIC_STAGES].x;
            sa_reg <= ra_reg[CORDIC_STAGES].neg ? -ra_reg[CORDIC_STAGES].y : ra_reg[CORDIC_STAGES].y;
            hd_reg[CORDIC_STAGES+1] <= hd_reg[CORDIC_STAGES];

            prod_d_reg <= PW'(cl_reg) * PW'(ca_reg);
            prod_x_reg <= PW'(cl_reg) * PW'(sa_reg);
            sl_m_reg   <= sl_reg;
            cl_m_reg   <= cl_reg;
            hd_reg[CORDIC_STAGES+2] <= hd_reg[CORDIC_STAGES+1];
        end
    end

    assign p_next = QW'(sl_m_reg) + QW'(ONE);

    // First branch stage: denominator, numerator magnitudes, log operands and pole tests.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg       <= DW'(prod_d_reg >>> FRAC) + DW'(ONE);
            nx0_reg.mag  <= NW'(prod_x_reg[PW-1] ? -prod_x_reg : prod_x_reg);
            nx0_reg.neg  <= prod_x_reg[PW-1];
            nx0_reg.zero <= (prod_x_reg == '0);
            ny0_reg.mag  <= NW'((sl_m_reg[CW-1] ? -PW'(sl_m_reg) : PW'(sl_m_reg)) <<< FRAC);
            ny0_reg.neg  <= sl_m_reg[CW-1];
            ny0_reg.zero <= (sl_m_reg == '0);

            lvp0_reg <= p_next[VW-1:0];
            lvc0_reg <= cl_m_reg[VW-1:0];

            tail_reg[0].mode     <= hd_reg[CORDIC_STAGES+2].mode;
            tail_reg[0].lon      <= hd_reg[CORDIC_STAGES+2].lon;
            tail_reg[0].m1x      <= QW'(prod_x_reg >>> FRAC);
            tail_reg[0].m1y      <= QW'(sl_m_reg);
            tail_reg[0].pole_neg <= p_next[QW-1] || (p_next == '0);
            tail_reg[0].pole_pos <= cl_m_reg[CW-1] || (cl_m_reg == '0);
        end
    end

    for (genvar t = 1; t < BR; t++)
    begin : g_tail
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tail_reg[t] <= tail_reg[t-1];
            end
        end
    end

    // A negative denominator flips the quotient signs and divides by its magnitude.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv1_reg     <= RW'(d0_reg[DW-1] ? -d0_reg : d0_reg);
            nx1_reg     <= '{mag: nx0_reg.mag, neg: nx0_reg.neg ^ d0_reg[DW-1],
                             zero: nx0_reg.zero};
            ny1_reg     <= '{mag: ny0_reg.mag, neg: ny0_reg.neg ^ d0_reg[DW-1],
                             zero: ny0_reg.zero};

            dv_reg[0]  <= dv1_reg;
            dlx_reg[0] <= div_init(nx1_reg, dv1_reg);
            dly_reg[0] <= div_init(ny1_reg, dv1_reg);

            lbp1_reg   <= lead_one(lvp0_reg);
            lbc1_reg   <= lead_one(lvc0_reg);
            lvp1_reg   <= lvp0_reg;
            lvc1_reg   <= lvc0_reg;

            lnp_reg[0] <= lane_init(lvp1_reg, lbp1_reg);
            lnc_reg[0] <= lane_init(lvc1_reg, lbc1_reg);
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j+1]  <= dv_reg[j];
                dlx_reg[j+1] <= div_step(dlx_reg[j], dv_reg[j]);
                dly_reg[j+1] <= div_step(dly_reg[j], dv_reg[j]);
            end
        end
    end

    for (genvar k = 0; k < HYP_STAGES; k++)
    begin : g_hyp
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lnp_reg[k+1].b <= lnp_reg[k].b;
                lnp_reg[k+1].h <= hyp_step(lnp_reg[k].h, hyp_shift(k));
                lnc_reg[k+1].b <= lnc_reg[k].b;
                lnc_reg[k+1].h <= hyp_step(lnc_reg[k].h, hyp_shift(k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lnp_reg_f <= ln_finish(lnp_reg[HYP_STAGES]);
            lnc_reg_f <= ln_finish(lnc_reg[HYP_STAGES]);
        end
    end

    assign tl = tail_reg[BR-1];

    always_comb
    begin
        xq_next = '0;
        yq_next = '0;
        unique case (tl.mode)
            MODE_STEREO:
            begin
                xq_next = q_value(dlx_reg[QB]);
                yq_next = q_value(dly_reg[QB]);
            end
            MODE_ORTHO:
            begin
                xq_next = tl.m1x;
                yq_next = tl.m1y;
            end
            MODE_MERCATOR:
            begin
                // Longitude passes through; Q13 doubled to Q14 rounds the same way.
                xq_next = QW'($signed(tl.lon)) <<< 1;
                if (tl.pole_neg) yq_next = -BIG_Q;
                else if (tl.pole_pos) yq_next = BIG_Q;
                else yq_next = lnp_reg_f - lnc_reg_f;
            end
            default:
            begin
                xq_next = '0;
                yq_next = '0;
            end
        endcase
    end

    assign sx = sat_q11(xq_reg);
    assign sy = sat_q11(yq_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xq_reg  <= xq_next;
            yq_reg  <= yq_next;
            px_reg  <= sx.val;
            py_reg  <= sy.val;
            sat_reg <= sx.clip | sy.clip;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.proj_x    = px_reg;
    assign result.proj_y    = py_reg;
    assign result.saturated = sat_reg;

endmodule

`default_nettype wire

>>> hdl/mpf_checker.sv
`default_nettype none

module mpf_props (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] proj_x,
    input logic signed [15:0] proj_y,
    input logic               saturated
);
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + 8'((in_valid && in_ready) ? 1 : 0)
                           - 8'((out_valid && out_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A result may only show for a point that was taken and not yet delivered.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 8'd0)
        else $error("result beat without an outstanding point");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({proj_x, proj_y, saturated}))
        else $error("stalled result changed");

    // An empty output stage must never hold off the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage empty");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (proj_x == 16'sh7FFF || proj_x == 16'sh8000 ||
             proj_y == 16'sh7FFF || proj_y == 16'sh8000))
        else $error("saturated flag without a clipped coordinate");

endmodule

bind map_projection_forward mpf_props u_mpf_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coord.valid),
    .in_ready  (coord.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .proj_x    (result.proj_x),
    .proj_y    (result.proj_y),
    .saturated (result.saturated)
);

`default_nettype wire

>>> tb/sv/mpf_checker.sv
`default_nettype none

module mpf_checker
    import mpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    mpf_in_if          coord,
    mpf_out_if         result,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               sat;
    } point_t;

    localparam int F = 14;
    localparam longint BIG = 64'sd1 << 40;

    point_t expected_points[$];
    logic [1:0] mode_shadow;
    longint atan_tab[0:17];
    longint atanh_tab[0:17];

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rescale(longint v, int from, int to);
        if (to >= from) return v * (64'sd1 << (to - from));
        return floor_shift(v + (64'sd1 << (from - to - 1)), from - to);
    endfunction

    function automatic longint arc_series(int i, bit alt);
        longint sum;
        longint term;
        int e;
        sum = 0;
        for (int k = 0; ; k++) begin
            e = i * (2 * k + 1);
            if (e > 62) break;
            term = (64'sd1 <<< (62 - e)) / (2 * k + 1);
            sum += (alt && k[0]) ? -term : term;
        end
        return sum;
    endfunction

    initial begin
        for (int i = 0; i < 18; i++) begin
            atan_tab[i] = floor_shift((i == 0) ? 64'sh3243F6A8885A308D
                                               : arc_series(i, 1'b1), 62 - F);
            atanh_tab[i] = (i == 0) ? 0 : floor_shift(arc_series(i, 1'b0), 62 - F);
        end
    end

    task automatic sin_cos(input longint a, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = floor_shift(64'h9B74EDA8, 32 - F);
        y = 0;
        z = a;
        flip = 0;
        if (z > floor_shift(64'sh3243F6A8885A308D, 61 - F)) begin
            z -= floor_shift(64'sh3243F6A8885A308D, 60 - F);
            flip = 1;
        end else if (z < -floor_shift(64'sh3243F6A8885A308D, 61 - F)) begin
            z += floor_shift(64'sh3243F6A8885A308D, 60 - F);
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint natural_log(longint v);
        int b;
        longint m, x, y, z, dx, dy;
        int reps;
        b = 62;
        z = 0;
        while (b > 0 && !v[b]) b--;
        m = longint'((longint'(unsigned'(v)) << (62 - b)) >> (62 - F));
        m = longint'(unsigned'(v << (62 - b)) >> (62 - F));
        x = m + (64'sd1 << F);
        y = m - (64'sd1 << F);
        for (int i = 1; i <= 16; i++) begin
            reps = (i == 4 || i == 13) ? 2 : 1;
            for (int r = 0; r < reps; r++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (y >= 0) begin
                    x -= dx; y -= dy; z += atanh_tab[i];
                end else begin
                    x += dx; y += dy; z -= atanh_tab[i];
                end
            end
        end
        return longint'(b - F) * floor_shift(64'sh2C5C85FDF473DE6A, 62 - F) + 2 * z;
    endfunction

    function automatic logic signed [15:0] clip_q11(longint v, int from, ref logic flag);
        longint r;
        r = rescale(v, from, 11);
        if (r > 32767) begin r = 32767; flag = 1; end
        if (r < -32768) begin r = -32768; flag = 1; end
        return r[15:0];
    endfunction

    function automatic longint big_of(longint v);
        return v > 0 ? BIG : (v < 0 ? -BIG : 0);
    endfunction

    task automatic project(input logic [1:0] m, input logic signed [15:0] lon_in,
                           input logic signed [15:0] lat_in, output point_t p);
        longint lon, lat, cl, sl, ca, sa, xq, yq, d, xn, yn, one;
        int xf;
        logic flag;
        lon = lon_in;
        lat = lat_in;
        one = 64'sd1 << F;
        xq = 0; yq = 0; xf = F; flag = 0;
        sin_cos(rescale(lat, 13, F), cl, sl);
        if (m == MODE_STEREO) begin
            sin_cos(rescale(lon, 14, F), ca, sa);
            d = one + floor_shift(cl * ca, F);
            xn = cl * sa;
            yn = sl * one;
            if (d < 0) begin d = -d; xn = -xn; yn = -yn; end
            if (d == 0) begin
                xq = big_of(xn); yq = big_of(yn);
            end else begin
                xq = xn / d; yq = yn / d;
            end
        end else if (m == MODE_ORTHO) begin
            sin_cos(rescale(lon, 13, F), ca, sa);
            xq = floor_shift(cl * sa, F);
            yq = sl;
        end else if (m == MODE_MERCATOR) begin
            xq = lon;
            xf = 13;
            if (one + sl <= 0) yq = -BIG;
            else if (cl <= 0) yq = BIG;
            else yq = natural_log(one + sl) - natural_log(cl);
        end
        p.x = clip_q11(xq, xf, flag);
        p.y = clip_q11(yq, F, flag);
        p.sat = flag;
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending = expected_points.size();

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        point_t p;
        point_t e;
        if (!rst_n) begin
            mode_shadow <= MODE_STEREO;
            expected_points.delete();
        end else begin
            if (coord.valid && coord.ready) begin
                project(mode_shadow, coord.longitude, coord.latitude, p);
                expected_points.push_back(p);
            end
            if (result.valid && result.ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    e = expected_points.pop_front();
                    if (result.proj_x !== e.x || result.proj_y !== e.y ||
                        result.saturated !== e.sat)
                        report_mismatch($sformatf("got x=%0d y=%0d s=%0b want x=%0d y=%0d s=%0b",
                            result.proj_x, result.proj_y, result.saturated,
                            e.x, e.y, e.sat));
                end
            end
            if (cfg_wr_en) mode_shadow <= cfg_wr_data;
        end
    end
endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mpf_pkg::*;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       cfg_wr_en = 0;
    logic [1:0] cfg_wr_data = '0;
    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_off = 0;

    mpf_in_if  coord ();
    mpf_out_if result ();

    map_projection_forward dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .coord(coord.sink), .result(result.source)
    );

    mpf_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .coord(coord), .result(result), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        coord.valid = 0;
        coord.longitude = '0;
        coord.latitude = '0;
        result.ready = 0;
    end

    always @(posedge clk)
    begin
        result.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_point(input logic signed [15:0] lon, input logic signed [15:0] lat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coord.valid <= 0;
            @(posedge clk);
        end
        coord.valid <= 1;
        coord.longitude <= lon;
        coord.latitude <= lat;
        @(posedge clk);
        while (!coord.ready) @(posedge clk);
    endtask

    task automatic drain_all();
        coord.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        cfg_wr_en <= 1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    // Mostly the expected ranges, sometimes anything, sometimes near the upper limit (the north pole for latitude).
    function automatic logic signed [15:0] pick_angle(int lim);
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'($urandom_range(2 * lim - 200, 2 * lim + 200) - lim);
        return 16'($urandom_range(2 * lim) - lim);
    endfunction

    initial
    begin
        logic signed [15:0] edge_vals[10] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1,
            16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736, 16'sd25000};
        logic [1:0] modes[8] = '{MODE_STEREO, MODE_ORTHO, MODE_MERCATOR, 2'd3,
            MODE_MERCATOR, MODE_ORTHO, MODE_STEREO, MODE_MERCATOR};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed corners in every mode, including the unused one.
        foreach (modes[m])
        begin
            if (m < 4)
            begin
                set_mode(modes[m]);
                for (int i = 0; i < 5; i++)
                    send_point(edge_vals[$urandom_range(9)], edge_vals[i * 2]);
                send_point(16'sh7FFF, 16'sh8000);
                send_point(16'sh8000, 16'sh7FFF);
                drain_all();
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            set_mode(modes[ph]);
            send_idle_pct = (ph < 3) ? 15 : (ph < 6 ? 79 : 0);
            recv_idle_pct = (ph < 3) ? 79 : (ph < 6 ? 15 : 0);
            if (ph == 6)
            begin
                // The receiver stops long enough for the pipeline to fill and stall.
                fork
                    begin
                        hold_off = 1;
                        repeat (150) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 190; n++)
                send_point(pick_angle(25736), pick_angle(12868));
            drain_all();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
